@@ rtl/cpd_pkg.sv @@
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared types and constants for the command packet deframer.
// ----------------------------------------------------------------------------
package cpd_pkg;

   localparam int MAX_PACKET_DEFAULT = 64;
   localparam int HELD_BYTES         = 24;
   localparam int STORE_IDX_W        = $clog2(HELD_BYTES + 1);

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam int RSP_FIELDS_W = 3 + 16 + 8 + 4 * 64 + 32;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [7:0] PKT_VERSION_OK = 8'd1;

   // register indexes on the configuration port
   localparam logic [2:0] REG_START_BYTE    = 3'd0;
   localparam logic [2:0] REG_CODE_CONTROL  = 3'd1;
   localparam logic [2:0] REG_CODE_PID_ALL  = 3'd2;
   localparam logic [2:0] REG_CODE_TARGET   = 3'd3;
   localparam logic [2:0] REG_CODE_SET_FLG  = 3'd4;
   localparam logic [2:0] REG_CODE_CLR_FLG  = 3'd5;

   typedef enum logic [2:0] {
      ST_IN_PROGRESS = 3'd0,
      ST_HUNTING     = 3'd1,
      ST_TOO_BIG     = 3'd2,
      ST_APPLIED     = 3'd3,
      ST_BAD_VERSION = 3'd4,
      ST_BAD_TYPE    = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] start_byte;
      logic [7:0] code_control;
      logic [7:0] code_pid_all;
      logic [7:0] code_target_speed;
      logic [7:0] code_set_flags;
      logic [7:0] code_clear_flags;
   } cfg_type;

endpackage

@@ rtl/cpd_csr.sv @@
// ----------------------------------------------------------------------------
// cpd_csr
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module cpd_csr
   import cpd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;
   logic [7:0] wr_byte;
   logic [7:0] rd_byte;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_byte    = csr_pwdata[7:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_START_BYTE:   cfg_in.start_byte        = wr_byte;
            REG_CODE_CONTROL: cfg_in.code_control      = wr_byte;
            REG_CODE_PID_ALL: cfg_in.code_pid_all      = wr_byte;
            REG_CODE_TARGET:  cfg_in.code_target_speed = wr_byte;
            REG_CODE_SET_FLG: cfg_in.code_set_flags    = wr_byte;
            REG_CODE_CLR_FLG: cfg_in.code_clear_flags  = wr_byte;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte        <= 8'd2;
         cfg_ff.code_control      <= 8'd0;
         cfg_ff.code_pid_all      <= 8'd1;
         cfg_ff.code_target_speed <= 8'd2;
         cfg_ff.code_set_flags    <= 8'd3;
         cfg_ff.code_clear_flags  <= 8'd4;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_START_BYTE:   rd_byte = cfg_ff.start_byte;
         REG_CODE_CONTROL: rd_byte = cfg_ff.code_control;
         REG_CODE_PID_ALL: rd_byte = cfg_ff.code_pid_all;
         REG_CODE_TARGET:  rd_byte = cfg_ff.code_target_speed;
         REG_CODE_SET_FLG: rd_byte = cfg_ff.code_set_flags;
         REG_CODE_CLR_FLG: rd_byte = cfg_ff.code_clear_flags;
         default:          rd_byte = 8'd0;
      endcase
   end

   assign csr_prdata = {{(CSR_DATA_W-8){1'b0}}, rd_byte};
   assign cfg        = cfg_ff;

endmodule

@@ rtl/command_packet_deframer.sv @@
// ----------------------------------------------------------------------------
// command_packet_deframer
// Parses start-byte, length-prefixed command packets and holds the settings.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one received byte per transfer. rsp_* returns exactly one
//   result per byte: a status code plus every held setting after that byte.
//   csr_* is an APB-style port holding the start byte and the five type codes;
//   write it only while no byte is in flight.
// Stages and throughput:
//   Two stage registers: input byte, then parser state / result, shown on
//   rsp_*. One byte per cycle is sustained while rsp_tready is high; the
//   parser updates in a single pass per byte.
// Reset:
//   Synchronous, active high. Parser hunts for the start byte, payload store
//   and held settings are cleared, registers return to their defaults.
// Stall:
//   When rsp_tready is low the result holds; one further byte may wait in the
//   input register, after which req_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module command_packet_deframer
   import cpd_pkg::*;
#(
   parameter int MAX_PACKET = MAX_PACKET_DEFAULT
)(
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: [7:0] rx_byte
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   // rsp_tdata: [2:0] status, [18:3] speed, [26:19] angle, [90:27] kp_bits,
   //   [154:91] ki_bits, [218:155] kd_bits, [282:219] target_bits,
   //   [314:283] flag_word, [319:315] zero
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int POS_W = $clog2(MAX_PACKET + 4);
   localparam logic [POS_W-1:0] POS_HUNT    = POS_W'(0);
   localparam logic [POS_W-1:0] POS_VERSION = POS_W'(1);
   localparam logic [POS_W-1:0] POS_TYPE    = POS_W'(2);
   localparam logic [POS_W-1:0] POS_SIZE_HI = POS_W'(3);
   localparam logic [POS_W-1:0] POS_SIZE_LO = POS_W'(4);
   localparam logic [16:0]      SIZE_LIMIT  = 17'(MAX_PACKET - 1);

   cfg_type cfg;

   cpd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // handshake / stage control
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       advance;
   logic       req_accept;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept)   in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (advance)         rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) in_byte_ff <= req_tdata;
   end

   // parser state
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [7:0]             version_ff, version_in;
   logic [7:0]             type_ff, type_in;
   logic [15:0]            size_ff, size_in;
   logic [STORE_IDX_W-1:0] widx_ff, widx_in;
   logic [7:0]             store_ff [HELD_BYTES];
   logic [7:0]             store_in [HELD_BYTES];
   status_type             status_ff, status_in;
   logic [15:0]            speed_ff, speed_in;
   logic [7:0]             angle_ff, angle_in;
   logic [63:0]            kp_ff, kp_in, ki_ff, ki_in, kd_ff, kd_in;
   logic [63:0]            target_ff, target_in;
   logic [31:0]            flags_ff, flags_in;

   logic [7:0]             b;
   logic [15:0]            size_lo;
   logic                   last_byte;
   logic [16:0]            payload_cnt;

   assign b           = in_byte_ff;
   assign size_lo     = {size_ff[15:8], b};
   assign payload_cnt = 17'(pos_ff) - 17'd4;

   always_comb begin
      pos_in     = pos_ff;
      version_in = version_ff;
      type_in    = type_ff;
      size_in    = size_ff;
      widx_in    = widx_ff;
      store_in   = store_ff;
      status_in  = ST_IN_PROGRESS;
      speed_in   = speed_ff;
      angle_in   = angle_ff;
      kp_in      = kp_ff;
      ki_in      = ki_ff;
      kd_in      = kd_ff;
      target_in  = target_ff;
      flags_in   = flags_ff;
      last_byte  = 1'b0;

      priority if (pos_ff == POS_HUNT) begin
         if (b == cfg.start_byte) begin
            widx_in = '0;
            pos_in  = POS_VERSION;
         end else begin
            status_in = ST_HUNTING;
         end
      end else if (pos_ff == POS_VERSION) begin
         version_in = b;
         pos_in     = POS_TYPE;
      end else if (pos_ff == POS_TYPE) begin
         type_in = b;
         pos_in  = POS_SIZE_HI;
      end else if (pos_ff == POS_SIZE_HI) begin
         size_in = {b, size_ff[7:0]};
         pos_in  = POS_SIZE_LO;
      end else if (pos_ff == POS_SIZE_LO) begin
         if ({1'b0, size_lo} > SIZE_LIMIT) begin
            widx_in   = '0;
            size_in   = '0;
            pos_in    = POS_HUNT;
            status_in = ST_TOO_BIG;
         end else begin
            size_in = size_lo;
            pos_in  = pos_ff + POS_W'(1);
         end
      end else begin
         if (widx_ff < STORE_IDX_W'(HELD_BYTES)) begin
            store_in[widx_ff] = b;
            widx_in           = widx_ff + STORE_IDX_W'(1);
         end
         if (payload_cnt >= {1'b0, size_ff}) begin
            last_byte = 1'b1;
            pos_in    = POS_HUNT;
            // entry after the last payload byte is cleared
            if (widx_in < STORE_IDX_W'(HELD_BYTES)) store_in[widx_in] = 8'd0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end

      if (last_byte) begin
         if (version_ff != PKT_VERSION_OK) begin
            status_in = ST_BAD_VERSION;
         end else begin
            status_in = ST_APPLIED;
            priority if (type_ff == cfg.code_control) begin
               speed_in = {store_in[0], store_in[1]};
               angle_in = store_in[2];
            end else if (type_ff == cfg.code_pid_all) begin
               for (int k = 0; k < 8; k++) begin
                  kp_in[63-8*k -: 8] = store_in[k];
                  ki_in[63-8*k -: 8] = store_in[k+8];
                  kd_in[63-8*k -: 8] = store_in[k+16];
               end
            end else if (type_ff == cfg.code_target_speed) begin
               for (int k = 0; k < 8; k++) begin
                  target_in[63-8*k -: 8] = store_in[k];
               end
            end else if (type_ff == cfg.code_set_flags) begin
               flags_in = flags_ff |
                          {store_in[0], store_in[1], store_in[2], store_in[3]};
            end else if (type_ff == cfg.code_clear_flags) begin
               flags_in = flags_ff &
                          ~{store_in[0], store_in[1], store_in[2], store_in[3]};
            end else begin
               status_in = ST_BAD_TYPE;
            end
         end
      end
   end

   // held settings double as the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= POS_HUNT;
         version_ff <= '0;
         type_ff    <= '0;
         size_ff    <= '0;
         widx_ff    <= '0;
         status_ff  <= ST_IN_PROGRESS;
         speed_ff   <= '0;
         angle_ff   <= '0;
         kp_ff      <= '0;
         ki_ff      <= '0;
         kd_ff      <= '0;
         target_ff  <= '0;
         flags_ff   <= '0;
         for (int i = 0; i < HELD_BYTES; i++) store_ff[i] <= '0;
      end else if (advance) begin
         pos_ff     <= pos_in;
         version_ff <= version_in;
         type_ff    <= type_in;
         size_ff    <= size_in;
         widx_ff    <= widx_in;
         status_ff  <= status_in;
         speed_ff   <= speed_in;
         angle_ff   <= angle_in;
         kp_ff      <= kp_in;
         ki_ff      <= ki_in;
         kd_ff      <= kd_in;
         target_ff  <= target_in;
         flags_ff   <= flags_in;
         store_ff   <= store_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-RSP_FIELDS_W){1'b0}}, flags_ff, target_ff,
                        kd_ff, ki_ff, kp_ff, angle_ff, speed_ff, status_ff};

endmodule

@@ dv/command_packet_deframer_checker.sv @@
// ----------------------------------------------------------------------------
// command_packet_deframer_checker
// Watches the byte, result and register ports of the deframer. It keeps its
// own copy of the parser state and held settings, predicts one report per
// accepted byte, and compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module command_packet_deframer_checker
   import cpd_pkg::*;
#(
   parameter int MAX_PACKET = MAX_PACKET_DEFAULT
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    mismatch_count,
   output int                    pending_count,
   output int                    checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      status_type  status;
      logic [15:0] speed;
      logic [7:0]  angle;
      logic [63:0] kp;
      logic [63:0] ki;
      logic [63:0] kd;
      logic [63:0] target;
      logic [31:0] flags;
   } deframe_report_type;

   localparam cfg_type CFG_AT_RESET = '{
      start_byte: 8'd2, code_control: 8'd0, code_pid_all: 8'd1,
      code_target_speed: 8'd2, code_set_flags: 8'd3, code_clear_flags: 8'd4
   };

   cfg_type            cfg;
   int unsigned        parse_pos;      // 0 while hunting
   logic [7:0]         pkt_version;
   logic [7:0]         pkt_kind;
   logic [15:0]        pkt_len;
   int unsigned        store_fill;
   logic [7:0]         payload [HELD_BYTES];
   logic [15:0]        held_speed;
   logic [7:0]         held_angle;
   logic [63:0]        held_kp;
   logic [63:0]        held_ki;
   logic [63:0]        held_kd;
   logic [63:0]        held_target;
   logic [31:0]        held_flags;
   deframe_report_type expected_reports [$];

   // big-endian read of the payload store, zeros beyond its end
   function automatic logic [63:0] payload_be(int unsigned first, int unsigned count);
      logic [63:0] acc;
      acc = '0;
      for (int unsigned k = first; k < first + count; k++) begin
         acc = {acc[55:0], (k < HELD_BYTES) ? payload[k] : 8'h00};
      end
      return acc;
   endfunction

   function automatic status_type apply_payload();
      if (pkt_version != PKT_VERSION_OK) return ST_BAD_VERSION;
      // first matching code wins
      if (pkt_kind == cfg.code_control) begin
         held_speed = 16'(payload_be(0, 2));
         held_angle = 8'(payload_be(2, 1));
      end else if (pkt_kind == cfg.code_pid_all) begin
         held_kp = payload_be(0, 8);
         held_ki = payload_be(8, 8);
         held_kd = payload_be(16, 8);
      end else if (pkt_kind == cfg.code_target_speed) begin
         held_target = payload_be(0, 8);
      end else if (pkt_kind == cfg.code_set_flags) begin
         held_flags = held_flags | 32'(payload_be(0, 4));
      end else if (pkt_kind == cfg.code_clear_flags) begin
         held_flags = held_flags & ~32'(payload_be(0, 4));
      end else begin
         return ST_BAD_TYPE;
      end
      return ST_APPLIED;
   endfunction

   function automatic deframe_report_type deframe_byte(logic [7:0] b);
      deframe_report_type r;
      status_type         st;
      st = ST_IN_PROGRESS;
      if (parse_pos == 0) begin
         if (b == cfg.start_byte) begin
            store_fill = 0;
            parse_pos  = 1;
         end else begin
            st = ST_HUNTING;
         end
      end else if (parse_pos == 1) begin
         pkt_version = b;
         parse_pos   = 2;
      end else if (parse_pos == 2) begin
         pkt_kind  = b;
         parse_pos = 3;
      end else if (parse_pos == 3) begin
         pkt_len   = {b, pkt_len[7:0]};
         parse_pos = 4;
      end else if (parse_pos == 4) begin
         pkt_len = {pkt_len[15:8], b};
         if (pkt_len > MAX_PACKET - 1) begin
            store_fill = 0;
            pkt_len    = '0;
            parse_pos  = 0;
            st         = ST_TOO_BIG;
         end else begin
            parse_pos = 5;
         end
      end else begin
         // bytes past the store are counted but dropped
         if (store_fill < HELD_BYTES) begin
            payload[store_fill] = b;
            store_fill++;
         end
         // a zero size still takes one payload byte
         if (parse_pos - 4 >= pkt_len) begin
            parse_pos = 0;
            if (store_fill < HELD_BYTES) payload[store_fill] = 8'h00;
            st = apply_payload();
         end else begin
            parse_pos++;
         end
      end
      r.status = st;
      r.speed  = held_speed;
      r.angle  = held_angle;
      r.kp     = held_kp;
      r.ki     = held_ki;
      r.kd     = held_kd;
      r.target = held_target;
      r.flags  = held_flags;
      return r;
   endfunction

   function automatic deframe_report_type unpack_report(logic [RSP_DATA_W-1:0] d);
      deframe_report_type r;
      r.status = status_type'(d[2:0]);
      r.speed  = d[18:3];
      r.angle  = d[26:19];
      r.kp     = d[90:27];
      r.ki     = d[154:91];
      r.kd     = d[218:155];
      r.target = d[282:219];
      r.flags  = d[314:283];
      return r;
   endfunction

   function automatic string report_text(deframe_report_type r);
      return $sformatf("status %0d speed %h angle %h kp %h ki %h kd %h target %h flags %h",
                       r.status, r.speed, r.angle, r.kp, r.ki, r.kd, r.target, r.flags);
   endfunction

   always @(posedge clock) begin
      deframe_report_type seen;
      deframe_report_type want;
      if (reset) begin
         cfg            = CFG_AT_RESET;
         parse_pos      = 0;
         pkt_version    = '0;
         pkt_kind       = '0;
         pkt_len        = '0;
         store_fill     = 0;
         foreach (payload[i]) payload[i] = 8'h00;
         held_speed     = '0;
         held_angle     = '0;
         held_kp        = '0;
         held_ki        = '0;
         held_kd        = '0;
         held_target    = '0;
         held_flags     = '0;
         mismatch_count = 0;
         checked_count  = 0;
         expected_reports.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_W-1:2])
               REG_START_BYTE:   cfg.start_byte        = csr_pwdata[7:0];
               REG_CODE_CONTROL: cfg.code_control      = csr_pwdata[7:0];
               REG_CODE_PID_ALL: cfg.code_pid_all      = csr_pwdata[7:0];
               REG_CODE_TARGET:  cfg.code_target_speed = csr_pwdata[7:0];
               REG_CODE_SET_FLG: cfg.code_set_flags    = csr_pwdata[7:0];
               REG_CODE_CLR_FLG: cfg.code_clear_flags  = csr_pwdata[7:0];
               default: ;
            endcase
         end
         // pop before push: a result never belongs to the byte taken at the same edge
         if (rsp_tvalid && rsp_tready) begin
            seen = unpack_report(rsp_tdata);
            if (expected_reports.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("tb: result transfer with no byte pending: %s", report_text(seen));
               end
            end else begin
               want = expected_reports.pop_front();
               checked_count++;
               if (seen.status !== want.status || seen.speed !== want.speed ||
                   seen.angle !== want.angle || seen.kp !== want.kp ||
                   seen.ki !== want.ki || seen.kd !== want.kd ||
                   seen.target !== want.target || seen.flags !== want.flags) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("tb: mismatch on result %0d", checked_count);
                     $display("tb:   expected %s", report_text(want));
                     $display("tb:   actual   %s", report_text(seen));
                  end
               end
            end
         end
         if (req_tvalid && req_tready) expected_reports.push_back(deframe_byte(req_tdata));
      end
      pending_count = expected_reports.size();
   end

endmodule

@@ dv/command_packet_deframer_tb.sv @@
// ----------------------------------------------------------------------------
// command_packet_deframer_tb
// Feeds framed command packets, noise and malformed headers into the
// deframer under several start-byte and type-code settings, with random
// gaps on the byte side and stalls on the result side. A checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module command_packet_deframer_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cpd_pkg::*;

   localparam int MAX_PACKET      = MAX_PACKET_DEFAULT;
   localparam int IDLE_LIMIT      = 2000;
   localparam int BYTES_PER_PHASE = 215;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int      mismatch_count;
   int      pending_count;
   int      checked_count;
   bit      allow_idle  = 1'b1;
   bit      idle_enable = 1'b0;
   int      stall_left  = 0;
   int      quiet_cycles = 0;
   int      bytes_sent = 0;
   int      noise_sent = 0;
   int      packets_sent = 0;
   int      oversize_sent = 0;
   cfg_type live_cfg;

   initial begin
      forever #10 clock = ~clock;
   end

   command_packet_deframer #(
      .MAX_PACKET(MAX_PACKET)
   ) i_dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   command_packet_deframer_checker #(
      .MAX_PACKET(MAX_PACKET)
   ) i_checker (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .mismatch_count, .pending_count, .checked_count
   );

   // result side back-pressure in bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else if (idle_enable && $urandom_range(0, 11) == 0) begin
         stall_left <= $urandom_range(1, 10);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("tb: no transfer for %0d cycles", IDLE_LIMIT);
         $display("tb: failure");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      if (idle_enable && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_header(input logic [7:0] ver, input logic [7:0] kind,
                              input logic [15:0] len);
      send_byte(live_cfg.start_byte);
      send_byte(ver);
      send_byte(kind);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
      packets_sent++;
      if (len > MAX_PACKET - 1) oversize_sent++;
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= {24'h0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
   endtask

   task automatic write_config(input cfg_type c);
      write_reg(REG_START_BYTE, c.start_byte);
      write_reg(REG_CODE_CONTROL, c.code_control);
      write_reg(REG_CODE_PID_ALL, c.code_pid_all);
      write_reg(REG_CODE_TARGET, c.code_target_speed);
      write_reg(REG_CODE_SET_FLG, c.code_set_flags);
      write_reg(REG_CODE_CLR_FLG, c.code_clear_flags);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      live_cfg = c;
   endtask

   // let every byte in flight come back before touching the registers
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic run_traffic(input int goal);
      int          pick;
      logic [7:0]  ver;
      logic [7:0]  kind;
      logic [15:0] len;
      while (bytes_sent - noise_sent < goal) begin
         idle_enable = allow_idle && ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            repeat ($urandom_range(1, 3)) begin
               send_byte(8'($urandom()));
               noise_sent++;
            end
         end else if (pick < 12) begin
            // start byte followed by a cut-off header
            send_byte(live_cfg.start_byte);
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom()));
         end else begin
            ver = ($urandom_range(0, 9) != 0) ? PKT_VERSION_OK : 8'($urandom());
            case ($urandom_range(0, 5))
               0:       kind = live_cfg.code_control;
               1:       kind = live_cfg.code_pid_all;
               2:       kind = live_cfg.code_target_speed;
               3:       kind = live_cfg.code_set_flags;
               4:       kind = live_cfg.code_clear_flags;
               default: kind = 8'($urandom());
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 40)      len = 16'($urandom_range(0, 4));
            else if (pick < 75) len = 16'($urandom_range(5, 30));
            else if (pick < 88) len = 16'($urandom_range(31, MAX_PACKET - 1));
            else                len = 16'($urandom_range(MAX_PACKET, 65535));
            send_header(ver, kind, len);
            if (len <= MAX_PACKET - 1) repeat (len + 1) send_byte(8'($urandom()));
         end
      end
   endtask

   initial begin
      cfg_type c;
      live_cfg = '{start_byte: 8'd2, code_control: 8'd0, code_pid_all: 8'd1,
                   code_target_speed: 8'd2, code_set_flags: 8'd3, code_clear_flags: 8'd4};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      idle_enable = 1'b1;

      // noise while hunting
      send_byte(8'h00);
      send_byte(8'hFF);
      // negative speed, zero angle from the cleared entry
      send_header(PKT_VERSION_OK, live_cfg.code_control, 16'd2);
      send_byte(8'h80);
      send_byte(8'h00);
      send_byte(8'hFF);
      // smallest size that is rejected
      send_header(PKT_VERSION_OK, live_cfg.code_set_flags, 16'(MAX_PACKET));
      send_header(8'hFF, live_cfg.code_set_flags, 16'd0);
      send_byte(8'hA5);
      // one-byte payload: flag word picks up the cleared entry and older bytes
      send_header(PKT_VERSION_OK, live_cfg.code_set_flags, 16'd0);
      send_byte(8'hFF);
      drain();

      for (int phase = 1; phase <= 6; phase++) begin
         case (phase)
            1: c = '{default: 8'h00};
            2: c = '{start_byte: 8'hFF, code_control: 8'hFF, code_pid_all: 8'hFE,
                     code_target_speed: 8'h80, code_set_flags: 8'h7F,
                     code_clear_flags: 8'h01};
            3: begin
               c.start_byte        = 8'($urandom());
               c.code_control      = 8'($urandom());
               c.code_pid_all      = 8'($urandom());
               c.code_target_speed = c.code_pid_all;
               c.code_set_flags    = 8'($urandom());
               c.code_clear_flags  = c.code_set_flags;
            end
            5: c = '{start_byte: 8'd2, code_control: 8'd0, code_pid_all: 8'd1,
                     code_target_speed: 8'd2, code_set_flags: 8'd3,
                     code_clear_flags: 8'd4};
            default: begin
               c.start_byte        = 8'($urandom());
               c.code_control      = 8'($urandom());
               c.code_pid_all      = 8'($urandom());
               c.code_target_speed = 8'($urandom());
               c.code_set_flags    = 8'($urandom());
               c.code_clear_flags  = 8'($urandom());
            end
         endcase
         if (phase == 6) begin
            allow_idle  = 1'b0;
            idle_enable = 1'b0;
         end
         write_config(c);
         run_traffic(BYTES_PER_PHASE * phase);
         drain();
      end

      repeat (4) @(posedge clock);
      $display("tb: %0d bytes sent, %0d packet headers (%0d oversize), %0d noise bytes",
               bytes_sent, packets_sent, oversize_sent, noise_sent);
      $display("tb: 7 register settings, %0d results compared, %0d mismatches",
               checked_count, mismatch_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/cpd_pkg.sv
rtl/cpd_csr.sv
rtl/command_packet_deframer.sv
dv/command_packet_deframer_checker.sv
dv/command_packet_deframer_tb.sv
